[design/triangle_voxel_overlap_test_assert.svh]
// ----------------------------------------------------------------------------
// triangle_voxel_overlap_test_assert.svh
// Assertion macros shared by the triangle / voxel overlap test.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_VOXEL_OVERLAP_TEST_ASSERT_SVH
`define TRIANGLE_VOXEL_OVERLAP_TEST_ASSERT_SVH

// same-cycle implication
`define TVO_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvo: implication failed");

// next-cycle implication
`define TVO_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvo: next-cycle implication failed");

`endif

[design/tvo_pkg.sv]
// ----------------------------------------------------------------------------
// tvo_pkg
// Widths, types and register codes of the triangle / voxel overlap test.
// ----------------------------------------------------------------------------
package tvo_pkg;

   localparam int COORD_BITS = 32;
   localparam int INDEX_BITS = 10;
   localparam int GRID_BITS  = INDEX_BITS + 1;
   localparam int SIZE_BITS  = 31;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;

   // (2*index+1) * voxel_size
   localparam int ODD_BITS   = INDEX_BITS + 1;
   localparam int SCALE_BITS = ODD_BITS + SIZE_BITS;
   // doubled, box-relative vertex coordinates
   localparam int T_BITS = ((COORD_BITS + 1 > SCALE_BITS) ? COORD_BITS + 1 : SCALE_BITS) + 2;
   // doubled edge vectors
   localparam int E_BITS = COORD_BITS + 2;
   // triangle normal
   localparam int N_BITS = 2 * E_BITS + 1;

   localparam int MUL_A_BITS   = N_BITS;
   localparam int MUL_B_BITS   = T_BITS;
   localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
   localparam int DIGIT_BITS   = 24;
   localparam int MUL_A_DIGITS = (MUL_A_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int MUL_B_DIGITS = (MUL_B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int SUM_BITS     = PROD_BITS + 2;

   localparam int NUM_STAGES  = 9;
   localparam int ST_CENTER   = 1;
   localparam int ST_SHIFT    = 2;
   localparam int ST_MUL_A    = 3;
   localparam int ST_MUL_B    = 4;
   localparam int ST_PROJ     = 5;
   localparam int ST_AXIS     = 6;
   localparam int ST_PLANE_B  = 7;
   localparam int ST_PLANE    = 8;
   localparam int ST_RESULT   = 9;

   localparam int REQ_FIELD_BITS = 9 * COORD_BITS + 3 * INDEX_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 + 3 * INDEX_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [SIZE_BITS-1:0] VSIZE_RESET = SIZE_BITS'(65536);
   localparam logic [GRID_BITS-1:0] GRID_RESET  = GRID_BITS'(1024);

   // cyclic neighbors of an axis or vertex index
   localparam int NEXT_IDX [3] = '{1, 2, 0};
   localparam int PREV_IDX [3] = '{2, 0, 1};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORIGIN_X    = 0,
      CSR_ORIGIN_Y    = 1,
      CSR_ORIGIN_Z    = 2,
      CSR_VOXEL_SIZE  = 3,
      CSR_GRID_SIZE_X = 4,
      CSR_GRID_SIZE_Y = 5,
      CSR_GRID_SIZE_Z = 6
   } csr_index_type;

   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] origin;
      logic [SIZE_BITS-1:0]       vsize;
      logic [2:0][GRID_BITS-1:0]  grid;
   } cfg_type;

   typedef struct packed {
      logic [2:0][2:0][COORD_BITS-1:0] vtx;   // [vertex][axis]
      logic [2:0][INDEX_BITS-1:0]      vox;
   } item_type;

   typedef struct packed {
      logic                       overlaps;
      logic                       out_of_grid;
      logic [2:0][INDEX_BITS-1:0] hit;
   } result_type;

   typedef logic [NUM_STAGES:1] stage_en_type;

endpackage

[design/tvo_mul.sv]
// ----------------------------------------------------------------------------
// tvo_mul
// Two-stage signed multiplier: digit partial products, then their sum.
// ----------------------------------------------------------------------------
module tvo_mul import tvo_pkg::*; (
   input  logic                          clock,
   input  logic [1:0]                    load,
   input  logic signed [MUL_A_BITS-1:0]  a,
   input  logic signed [MUL_B_BITS-1:0]  b,
   output logic signed [PROD_BITS-1:0]   prod
);

   logic signed [DIGIT_BITS:0]     ad [MUL_A_DIGITS];
   logic signed [DIGIT_BITS:0]     bd [MUL_B_DIGITS];
   logic signed [2*DIGIT_BITS+1:0] pp_in [MUL_A_DIGITS][MUL_B_DIGITS];
   logic signed [2*DIGIT_BITS+1:0] pp_ff [MUL_A_DIGITS][MUL_B_DIGITS];
   logic signed [PROD_BITS-1:0]    sum_in;
   logic signed [PROD_BITS-1:0]    prod_ff;

   // low digits unsigned, top digit carries the sign
   for (genvar i = 0; i < MUL_A_DIGITS; i++) begin : g_a
      if (i == MUL_A_DIGITS - 1) begin : g_top
         assign ad[i] = (DIGIT_BITS+1)'($signed(a[MUL_A_BITS-1:DIGIT_BITS*i]));
      end else begin : g_low
         assign ad[i] = $signed({1'b0, a[DIGIT_BITS*i +: DIGIT_BITS]});
      end
   end

   for (genvar j = 0; j < MUL_B_DIGITS; j++) begin : g_b
      if (j == MUL_B_DIGITS - 1) begin : g_top
         assign bd[j] = (DIGIT_BITS+1)'($signed(b[MUL_B_BITS-1:DIGIT_BITS*j]));
      end else begin : g_low
         assign bd[j] = $signed({1'b0, b[DIGIT_BITS*j +: DIGIT_BITS]});
      end
   end

   always_comb begin
      for (int i = 0; i < MUL_A_DIGITS; i++) begin
         for (int j = 0; j < MUL_B_DIGITS; j++) begin
            pp_in[i][j] = ad[i] * bd[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         pp_ff <= pp_in;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MUL_A_DIGITS; i++) begin
         for (int j = 0; j < MUL_B_DIGITS; j++) begin
            sum_in = sum_in + (PROD_BITS'(pp_ff[i][j]) <<< (DIGIT_BITS * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         prod_ff <= sum_in;
      end
   end

   assign prod = prod_ff;

endmodule

[design/tvo_core.sv]
// ----------------------------------------------------------------------------
// tvo_core
// Nine-stage datapath of the separating-axis triangle / box test.
// Coordinates are doubled so the half voxel is the integer voxel_size.
// ----------------------------------------------------------------------------
module tvo_core import tvo_pkg::*; (
   input  logic         clock,
   input  stage_en_type en,
   input  cfg_type      cfg,
   input  item_type     item,
   output result_type   result
);

   logic [SCALE_BITS-1:0]        scale1 [3];
   logic signed [T_BITS-1:0]     c2_in [3];
   logic signed [T_BITS-1:0]     c2_ff [3];
   logic signed [COORD_BITS-1:0] v1_ff [3][3];
   logic signed [E_BITS-1:0]     e1_in [3][3];
   logic signed [E_BITS-1:0]     e1_ff [3][3];
   logic signed [E_BITS-1:0]     e2_ff [3][3];
   logic signed [T_BITS-1:0]     t2_in [3][3];
   logic signed [T_BITS-1:0]     t2_ff [3][3];
   logic [E_BITS-1:0]            s2_in [3][3];
   logic [E_BITS-1:0]            s2_ff [3][3];
   logic signed [T_BITS-1:0]     half_t;
   logic signed [MUL_B_BITS-1:0] h_b;
   logic                         box3_in;
   logic signed [T_BITS-1:0]     t0_ff [ST_MUL_A:ST_PROJ][3];
   logic signed [PROD_BITS-1:0]  pa4 [3][3][2];
   logic signed [PROD_BITS-1:0]  pb4 [3][3][2];
   logic signed [PROD_BITS-1:0]  rad4 [3][3];
   logic signed [PROD_BITS-1:0]  na4 [3];
   logic signed [PROD_BITS-1:0]  nb4 [3];
   logic signed [PROD_BITS-1:0]  p5_ff [3][3][2];
   logic signed [PROD_BITS-1:0]  rad5_ff [3][3];
   logic signed [N_BITS-1:0]     n5_ff [3];
   logic                         axis6_in;
   logic signed [PROD_BITS-1:0]  nt7 [3];
   logic signed [PROD_BITS-1:0]  nh7 [3];
   logic signed [SUM_BITS-1:0]   d8_in;
   logic signed [SUM_BITS-1:0]   r8_in;
   logic signed [SUM_BITS-1:0]   d8_ff;
   logic signed [SUM_BITS-1:0]   r8_ff;
   logic                         plane9;
   logic                         hit9_in;
   logic                         hit9_ff;
   logic                         oog1_in;
   logic                         oog_ff [1:NUM_STAGES];
   logic [INDEX_BITS-1:0]        idx_ff [1:NUM_STAGES][3];
   logic                         fail_in [ST_MUL_A:ST_PLANE];
   logic                         fail_ff [ST_MUL_A:ST_PLANE];

   function automatic logic [E_BITS-1:0] abs_e(input logic signed [E_BITS-1:0] x);
      return x[E_BITS-1] ? E_BITS'(-x) : E_BITS'(x);
   endfunction

   // ---- stage 1: doubled box center, doubled edges, grid check
   always_comb begin
      oog1_in = 1'b0;
      for (int q = 0; q < 3; q++) begin
         scale1[q] = SCALE_BITS'({item.vox[q], 1'b1}) * SCALE_BITS'(cfg.vsize);
         c2_in[q]  = (T_BITS'($signed(cfg.origin[q])) <<< 1)
                   + T_BITS'($signed({1'b0, scale1[q]}));
         if ({1'b0, item.vox[q]} >= cfg.grid[q]) begin
            oog1_in = 1'b1;
         end
         for (int k = 0; k < 3; k++) begin
            e1_in[k][q] = (E_BITS'($signed(item.vtx[NEXT_IDX[k]][q]))
                         - E_BITS'($signed(item.vtx[k][q]))) <<< 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_CENTER]) begin
         c2_ff <= c2_in;
         e1_ff <= e1_in;
         for (int q = 0; q < 3; q++) begin
            for (int v = 0; v < 3; v++) begin
               v1_ff[v][q] <= item.vtx[v][q];
            end
         end
      end
   end

   // ---- stage 2: box-relative vertices, radius weights
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int q = 0; q < 3; q++) begin
            t2_in[v][q] = (T_BITS'(v1_ff[v][q]) <<< 1) - c2_ff[q];
         end
      end
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            s2_in[k][m] = abs_e(e1_ff[k][NEXT_IDX[m]]) + abs_e(e1_ff[k][PREV_IDX[m]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SHIFT]) begin
         t2_ff <= t2_in;
         e2_ff <= e1_ff;
         s2_ff <= s2_in;
      end
   end

   // ---- stage 3: box axes; edge-axis and normal products start
   assign half_t = T_BITS'($signed({1'b0, cfg.vsize}));
   assign h_b    = MUL_B_BITS'($signed({1'b0, cfg.vsize}));

   always_comb begin
      box3_in = 1'b0;
      for (int q = 0; q < 3; q++) begin
         if ((t2_ff[0][q] > half_t && t2_ff[1][q] > half_t && t2_ff[2][q] > half_t) ||
             (t2_ff[0][q] < -half_t && t2_ff[1][q] < -half_t &&
              t2_ff[2][q] < -half_t)) begin
            box3_in = 1'b1;
         end
      end
   end

   // axis (k, m) is unit_m x edge_k; vertices k and k+1 project alike
   for (genvar k = 0; k < 3; k++) begin : g_edge
      for (genvar m = 0; m < 3; m++) begin : g_axis
         for (genvar w = 0; w < 2; w++) begin : g_vert
            localparam int VV = (w == 0) ? k : PREV_IDX[k];
            tvo_mul u_mul_p (
               .clock (clock),
               .load  ({en[ST_MUL_B], en[ST_MUL_A]}),
               .a     (MUL_A_BITS'(e2_ff[k][NEXT_IDX[m]])),
               .b     (t2_ff[VV][PREV_IDX[m]]),
               .prod  (pa4[k][m][w])
            );
            tvo_mul u_mul_q (
               .clock (clock),
               .load  ({en[ST_MUL_B], en[ST_MUL_A]}),
               .a     (MUL_A_BITS'(e2_ff[k][PREV_IDX[m]])),
               .b     (t2_ff[VV][NEXT_IDX[m]]),
               .prod  (pb4[k][m][w])
            );
         end
         tvo_mul u_mul_rad (
            .clock (clock),
            .load  ({en[ST_MUL_B], en[ST_MUL_A]}),
            .a     (MUL_A_BITS'($signed({1'b0, s2_ff[k][m]}))),
            .b     (h_b),
            .prod  (rad4[k][m])
         );
      end
   end

   for (genvar q = 0; q < 3; q++) begin : g_norm
      tvo_mul u_mul_na (
         .clock (clock),
         .load  ({en[ST_MUL_B], en[ST_MUL_A]}),
         .a     (MUL_A_BITS'(e2_ff[0][NEXT_IDX[q]])),
         .b     (MUL_B_BITS'(e2_ff[1][PREV_IDX[q]])),
         .prod  (na4[q])
      );
      tvo_mul u_mul_nb (
         .clock (clock),
         .load  ({en[ST_MUL_B], en[ST_MUL_A]}),
         .a     (MUL_A_BITS'(e2_ff[0][PREV_IDX[q]])),
         .b     (MUL_B_BITS'(e2_ff[1][NEXT_IDX[q]])),
         .prod  (nb4[q])
      );
      // plane products: n . t0 and n * h
      tvo_mul u_mul_nt (
         .clock (clock),
         .load  ({en[ST_PLANE_B], en[ST_AXIS]}),
         .a     (n5_ff[q]),
         .b     (t0_ff[ST_PROJ][q]),
         .prod  (nt7[q])
      );
      tvo_mul u_mul_nh (
         .clock (clock),
         .load  ({en[ST_PLANE_B], en[ST_AXIS]}),
         .a     (n5_ff[q]),
         .b     (h_b),
         .prod  (nh7[q])
      );
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL_A]) begin
         t0_ff[ST_MUL_A] <= t2_ff[0];
      end
      if (en[ST_MUL_B]) begin
         t0_ff[ST_MUL_B] <= t0_ff[ST_MUL_A];
      end
      if (en[ST_PROJ]) begin
         t0_ff[ST_PROJ] <= t0_ff[ST_MUL_B];
      end
   end

   // ---- stage 5: projections and normal
   always_ff @(posedge clock) begin
      if (en[ST_PROJ]) begin
         rad5_ff <= rad4;
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               for (int w = 0; w < 2; w++) begin
                  p5_ff[k][m][w] <= pa4[k][m][w] - pb4[k][m][w];
               end
            end
         end
         for (int q = 0; q < 3; q++) begin
            n5_ff[q] <= N_BITS'(na4[q] - nb4[q]);
         end
      end
   end

   // ---- stage 6: edge-axis separation
   always_comb begin
      axis6_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            if ((p5_ff[k][m][0] > rad5_ff[k][m] && p5_ff[k][m][1] > rad5_ff[k][m]) ||
                ((p5_ff[k][m][0] + rad5_ff[k][m]) < 0 &&
                 (p5_ff[k][m][1] + rad5_ff[k][m]) < 0)) begin
               axis6_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      fail_in[ST_MUL_A]   = box3_in;
      fail_in[ST_MUL_B]   = fail_ff[ST_MUL_A];
      fail_in[ST_PROJ]    = fail_ff[ST_MUL_B];
      fail_in[ST_AXIS]    = fail_ff[ST_PROJ] | axis6_in;
      fail_in[ST_PLANE_B] = fail_ff[ST_AXIS];
      fail_in[ST_PLANE]   = fail_ff[ST_PLANE_B];
   end

   always_ff @(posedge clock) begin
      for (int s = ST_MUL_A; s <= ST_PLANE; s++) begin
         if (en[s]) begin
            fail_ff[s] <= fail_in[s];
         end
      end
      if (en[ST_CENTER]) begin
         oog_ff[1] <= oog1_in;
         for (int q = 0; q < 3; q++) begin
            idx_ff[1][q] <= item.vox[q];
         end
      end
      for (int s = 2; s <= NUM_STAGES; s++) begin
         if (en[s]) begin
            oog_ff[s] <= oog_ff[s-1];
            idx_ff[s] <= idx_ff[s-1];
         end
      end
   end

   // ---- stage 8: plane offset and radius
   always_comb begin
      d8_in = SUM_BITS'(nt7[0]) + SUM_BITS'(nt7[1]) + SUM_BITS'(nt7[2]);
      r8_in = '0;
      for (int q = 0; q < 3; q++) begin
         r8_in = r8_in + (nh7[q][PROD_BITS-1] ? -SUM_BITS'(nh7[q]) : SUM_BITS'(nh7[q]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PLANE]) begin
         d8_ff <= d8_in;
         r8_ff <= r8_in;
      end
   end

   // ---- stage 9: plane test, result register
   assign plane9  = (d8_ff > r8_ff) || ((d8_ff + r8_ff) < 0);
   assign hit9_in = !oog_ff[ST_PLANE] && !fail_ff[ST_PLANE] && !plane9;

   always_ff @(posedge clock) begin
      if (en[ST_RESULT]) begin
         hit9_ff <= hit9_in;
      end
   end

   always_comb begin
      result.overlaps    = hit9_ff;
      result.out_of_grid = oog_ff[ST_RESULT];
      for (int q = 0; q < 3; q++) begin
         result.hit[q] = idx_ff[ST_RESULT][q];
      end
   end

endmodule

[design/triangle_voxel_overlap_test.sv]
// ----------------------------------------------------------------------------
// triangle_voxel_overlap_test
// Separating-axis overlap test of one triangle against one grid voxel.
//
//   port group  dir  contents
//   req_*       in   three vertices and a voxel index triple
//   rsp_*       out  overlap flag, out-of-grid flag, echoed index
//   csr_*       in   origin, voxel size and grid size writes
//
// One transfer per cycle in each direction while the output is not stalled;
// a result passes nine register stages, set by two chained two-stage
// multiplier banks (edge axes and normal, then the plane products). Every
// stage holds its own valid bit and moves when the next one is free, so
// bubbles close up and a stalled output loses nothing.
// Reset (synchronous) empties the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
`include "triangle_voxel_overlap_test_assert.svh"

module triangle_voxel_overlap_test import tvo_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, cell_i, cell_j, cell_k
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // overlaps, out_of_grid, hit_i, hit_j, hit_k
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type      cfg_ff;
   item_type     item;
   result_type   result;
   stage_en_type en;
   logic [NUM_STAGES:1] vld_ff;
   logic [NUM_STAGES:1] vld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.vsize  <= VSIZE_RESET;
         for (int q = 0; q < 3; q++) begin
            cfg_ff.grid[q] <= GRID_RESET;
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:    cfg_ff.origin[0] <= csr_wdata[COORD_BITS-1:0];
            CSR_ORIGIN_Y:    cfg_ff.origin[1] <= csr_wdata[COORD_BITS-1:0];
            CSR_ORIGIN_Z:    cfg_ff.origin[2] <= csr_wdata[COORD_BITS-1:0];
            CSR_VOXEL_SIZE:  cfg_ff.vsize     <= csr_wdata[SIZE_BITS-1:0];
            CSR_GRID_SIZE_X: cfg_ff.grid[0]   <= csr_wdata[GRID_BITS-1:0];
            CSR_GRID_SIZE_Y: cfg_ff.grid[1]   <= csr_wdata[GRID_BITS-1:0];
            CSR_GRID_SIZE_Z: cfg_ff.grid[2]   <= csr_wdata[GRID_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // a stage advances when empty or when the stage after it advances
   always_comb begin
      en[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp_tready;
      for (int s = NUM_STAGES - 1; s >= 1; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
      vld_in[1] = en[1] ? req_tvalid : vld_ff[1];
      for (int s = 2; s <= NUM_STAGES; s++) begin
         vld_in[s] = en[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int q = 0; q < 3; q++) begin
            item.vtx[v][q] = req_tdata[(3*v + q)*COORD_BITS +: COORD_BITS];
         end
      end
      for (int q = 0; q < 3; q++) begin
         item.vox[q] = req_tdata[9*COORD_BITS + q*INDEX_BITS +: INDEX_BITS];
      end
   end

   tvo_core u_core (
      .clock  (clock),
      .en     (en),
      .cfg    (cfg_ff),
      .item   (item),
      .result (result)
   );

   assign req_tready = en[1];
   assign rsp_tvalid = vld_ff[NUM_STAGES];
   assign rsp_tdata  = RSP_DATA_BITS'({result.hit[2], result.hit[1], result.hit[0],
                                       result.out_of_grid, result.overlaps});

   `TVO_ASSERT_IMP(a_empty_out_takes_req, clock, reset, !rsp_tvalid, req_tready)
   `TVO_ASSERT_IMP(a_oog_never_hits, clock, reset, rsp_tvalid && rsp_tdata[1], !rsp_tdata[0])
   `TVO_ASSERT_IMP(a_out_from_stage8, clock, reset, $rose(rsp_tvalid), $past(vld_ff[NUM_STAGES-1]))
   `TVO_ASSERT_NXT(a_req_enters_stage1, clock, reset, req_tvalid && req_tready, vld_ff[1])

endmodule
